// ===== rtl/core/fbik_pkg.sv =====
// Shared constants, sideband types and the arctangent table of the
// five-bar delta inverse kinematics pipeline. No dependencies.
`default_nettype none

package fbik_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int ARM_W           = 14;
  localparam int ANGLE_W         = 16;
  localparam int OUT_W           = 16;
  localparam int CFG_IDX_W       = 4;
  localparam int CFG_DATA_W      = 16;

  localparam int SUM_W    = ARM_W + 1;
  localparam int SQ_W     = 2 * SUM_W;
  localparam int K_W      = 2 * SQ_W;
  localparam int S_W      = SQ_W;
  localparam int SQ_REM_W = S_W + 4;
  localparam int A_W      = 32;
  localparam int N_W      = 48;
  localparam int Q_W      = 16;
  localparam int NORM_STEPS   = 6;
  localparam int CORDIC_STEPS = 16;
  localparam int XY_W     = 50;
  localparam int Z_W      = 20;

  localparam int SIDE_LAT = 4 + S_W + 3 + Q_W + 1 + NORM_STEPS + 1 + CORDIC_STEPS + 1;

  localparam logic signed [Z_W-1:0]     HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX   = 16'sd25736;

  localparam logic [ARM_W-1:0]          HALF_BASE_RST  = 14'd800;
  localparam logic [ARM_W-1:0]          UPPER_ARM_RST  = 14'd2400;
  localparam logic [ARM_W-1:0]          LOWER_ARM_RST  = 14'd4800;
  localparam logic signed [ANGLE_W-1:0] SAFE_ANGLE_RST = 16'sd12868;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_BASE  = 4'd0,
    REG_UPPER_ARM  = 4'd1,
    REG_LOWER_ARM  = 4'd2,
    REG_SAFE_ANGLE = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                  bad;
    logic signed [15:0]    bx;
    logic signed [15:0]    dx;
    logic signed [15:0]    dy;
    logic signed [A_W-1:0] a;
    logic [SQ_W-1:0]       d2;
  } sq_side_t;

  typedef struct packed {
    logic                  bad;
    logic signed [15:0]    bx;
    logic signed [N_W-1:0] nx;
    logic signed [N_W-1:0] ny;
  } dv_side_t;

  typedef struct packed {
    logic                    bad;
    logic                    zero;
    logic signed [OUT_W-1:0] ex;
    logic signed [OUT_W-1:0] ey;
  } cd_side_t;

  function automatic logic signed [Z_W-1:0] atan_q16(input int step);
    logic signed [Z_W-1:0] val;
    case (step)
      0:       val = 20'sd51472;
      1:       val = 20'sd30385;
      2:       val = 20'sd16055;
      3:       val = 20'sd8150;
      4:       val = 20'sd4091;
      5:       val = 20'sd2047;
      6:       val = 20'sd1024;
      7:       val = 20'sd512;
      8:       val = 20'sd256;
      9:       val = 20'sd128;
      10:      val = 20'sd64;
      11:      val = 20'sd32;
      12:      val = 20'sd16;
      13:      val = 20'sd8;
      14:      val = 20'sd4;
      15:      val = 20'sd2;
      default: val = 20'sd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fbik_sqrt_cell.sv =====
// One stage of the pipelined integer square root: one root bit per cell.
// Depends on fbik_pkg.
`default_nettype none

module fbik_sqrt_cell #(
  parameter int SW = 1
) (
  input  logic                          clk,
  input  logic [fbik_pkg::K_W-1:0]      rad_in,
  input  logic [fbik_pkg::SQ_REM_W-1:0] rem_in,
  input  logic [fbik_pkg::S_W-1:0]      root_in,
  input  logic [SW-1:0]                 side_in,
  output logic [fbik_pkg::K_W-1:0]      rad_out,
  output logic [fbik_pkg::SQ_REM_W-1:0] rem_out,
  output logic [fbik_pkg::S_W-1:0]      root_out,
  output logic [SW-1:0]                 side_out
);

  logic [fbik_pkg::SQ_REM_W-1:0] part;
  logic [fbik_pkg::SQ_REM_W-1:0] trial;

  always_comb begin
    part  = {rem_in[fbik_pkg::SQ_REM_W-3:0], rad_in[fbik_pkg::K_W-1 -: 2]};
    trial = {{(fbik_pkg::SQ_REM_W - fbik_pkg::S_W - 2){1'b0}}, root_in, 2'b01};
  end

  always_ff @(posedge clk) begin
    rad_out  <= {rad_in[fbik_pkg::K_W-3:0], 2'b00};
    side_out <= side_in;
    if (part >= trial) begin
      rem_out  <= part - trial;
      root_out <= {root_in[fbik_pkg::S_W-2:0], 1'b1};
    end else begin
      rem_out  <= part;
      root_out <= {root_in[fbik_pkg::S_W-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fbik_div_cell.sv =====
// One stage of the pipelined restoring divider, two dividends over one
// divisor, one quotient bit per cell. Depends on fbik_pkg.
`default_nettype none

module fbik_div_cell #(
  parameter int SW = 1
) (
  input  logic                     clk,
  input  logic [fbik_pkg::N_W-1:0] remx_in,
  input  logic [fbik_pkg::N_W-1:0] remy_in,
  input  logic [fbik_pkg::Q_W-1:0] qx_in,
  input  logic [fbik_pkg::Q_W-1:0] qy_in,
  input  logic [fbik_pkg::N_W-1:0] dsh_in,
  input  logic [SW-1:0]            side_in,
  output logic [fbik_pkg::N_W-1:0] remx_out,
  output logic [fbik_pkg::N_W-1:0] remy_out,
  output logic [fbik_pkg::Q_W-1:0] qx_out,
  output logic [fbik_pkg::Q_W-1:0] qy_out,
  output logic [fbik_pkg::N_W-1:0] dsh_out,
  output logic [SW-1:0]            side_out
);

  logic gex;
  logic gey;

  assign gex = remx_in >= dsh_in;
  assign gey = remy_in >= dsh_in;

  always_ff @(posedge clk) begin
    remx_out <= gex ? remx_in - dsh_in : remx_in;
    remy_out <= gey ? remy_in - dsh_in : remy_in;
    qx_out   <= {qx_in[fbik_pkg::Q_W-2:0], gex};
    qy_out   <= {qy_in[fbik_pkg::Q_W-2:0], gey};
    dsh_out  <= dsh_in >> 1;
    side_out <= side_in;
  end

endmodule

`default_nettype wire

// ===== rtl/core/fbik_cordic_cell.sv =====
// One vectoring rotation of the CORDIC arctangent, with its table angle.
// Depends on fbik_pkg.
`default_nettype none

module fbik_cordic_cell #(
  parameter int SW   = 1,
  parameter int STEP = 0
) (
  input  logic                             clk,
  input  logic signed [fbik_pkg::XY_W-1:0] x_in,
  input  logic signed [fbik_pkg::XY_W-1:0] y_in,
  input  logic signed [fbik_pkg::Z_W-1:0]  z_in,
  input  logic [SW-1:0]                    side_in,
  output logic signed [fbik_pkg::XY_W-1:0] x_out,
  output logic signed [fbik_pkg::XY_W-1:0] y_out,
  output logic signed [fbik_pkg::Z_W-1:0]  z_out,
  output logic [SW-1:0]                    side_out
);

  logic signed [fbik_pkg::XY_W-1:0] xs;
  logic signed [fbik_pkg::XY_W-1:0] ys;

  assign xs = x_in >>> STEP;
  assign ys = y_in >>> STEP;

  always_ff @(posedge clk) begin
    side_out <= side_in;
    if (y_in > 0) begin
      x_out <= x_in + ys;
      y_out <= y_in - xs;
      z_out <= z_in + fbik_pkg::atan_q16(STEP);
    end else begin
      x_out <= x_in - ys;
      y_out <= y_in + xs;
      z_out <= z_in - fbik_pkg::atan_q16(STEP);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fbik_side.sv =====
// Full pipeline for one arm: circle intersection, elbow point and servo angle.
// Depends on fbik_pkg, fbik_sqrt_cell, fbik_div_cell and fbik_cordic_cell.
`default_nettype none

module fbik_side #(
  parameter int   CW   = fbik_pkg::COORD_WIDTH_DEF,
  parameter logic LEFT = 1'b0
) (
  input  logic                                  clk,
  input  logic signed [CW-1:0]                  tx,
  input  logic signed [CW-1:0]                  ty,
  input  logic [fbik_pkg::ARM_W-1:0]            hb,
  input  logic [fbik_pkg::SUM_W-1:0]            arm_sum,
  input  logic [fbik_pkg::SQ_W-1:0]             sum2,
  input  logic [fbik_pkg::SQ_W-1:0]             diff2,
  input  logic signed [fbik_pkg::A_W-1:0]       u2ml2,
  output logic                                  bad,
  output logic signed [fbik_pkg::OUT_W-1:0]     ex,
  output logic signed [fbik_pkg::OUT_W-1:0]     ey,
  output logic signed [fbik_pkg::ANGLE_W-1:0]   angle
);

  localparam int DXW = ((CW > fbik_pkg::SUM_W) ? CW : fbik_pkg::SUM_W) + 1;
  localparam int SW_SQ = $bits(fbik_pkg::sq_side_t);
  localparam int SW_DV = $bits(fbik_pkg::dv_side_t);
  localparam int SW_CD = $bits(fbik_pkg::cd_side_t);

  // Offset and range test against the arm reach.
  logic signed [15:0]    bx;
  logic signed [DXW-1:0] dxw;
  logic signed [DXW-1:0] dyw;
  logic [DXW-1:0]        adxw;
  logic [DXW-1:0]        adyw;

  logic                             s1_bad;
  logic signed [15:0]               s1_bx, s1_dx, s1_dy;
  logic [fbik_pkg::SUM_W-1:0]       s1_adx, s1_ady;

  assign bx   = LEFT ? -$signed({2'b00, hb}) : $signed({2'b00, hb});
  assign dxw  = DXW'(tx) - DXW'(bx);
  assign dyw  = DXW'(ty);
  assign adxw = dxw[DXW-1] ? DXW'(-dxw) : DXW'(dxw);
  assign adyw = dyw[DXW-1] ? DXW'(-dyw) : DXW'(dyw);

  always_ff @(posedge clk) begin
    s1_bad <= (adxw > DXW'(arm_sum)) || (adyw > DXW'(arm_sum));
    s1_bx  <= bx;
    s1_dx  <= dxw[15:0];
    s1_dy  <= dyw[15:0];
    s1_adx <= adxw[fbik_pkg::SUM_W-1:0];
    s1_ady <= adyw[fbik_pkg::SUM_W-1:0];
  end

  logic                        s2_bad;
  logic signed [15:0]          s2_bx, s2_dx, s2_dy;
  logic [fbik_pkg::SQ_W-1:0]   s2_sqx, s2_sqy;

  always_ff @(posedge clk) begin
    s2_bad <= s1_bad;
    s2_bx  <= s1_bx;
    s2_dx  <= s1_dx;
    s2_dy  <= s1_dy;
    s2_sqx <= s1_adx * s1_adx;
    s2_sqy <= s1_ady * s1_ady;
  end

  logic [fbik_pkg::SQ_W:0]         d2w;
  logic                            s3_bad;
  logic signed [15:0]              s3_bx, s3_dx, s3_dy;
  logic [fbik_pkg::SQ_W-1:0]       s3_ka, s3_kb, s3_d2;
  logic signed [fbik_pkg::A_W-1:0] s3_a;

  assign d2w = {1'b0, s2_sqx} + {1'b0, s2_sqy};

  always_ff @(posedge clk) begin
    s3_bad <= s2_bad || (d2w == '0) || (d2w < {1'b0, diff2}) || (d2w > {1'b0, sum2});
    s3_bx  <= s2_bx;
    s3_dx  <= s2_dx;
    s3_dy  <= s2_dy;
    s3_ka  <= d2w[fbik_pkg::SQ_W-1:0] - diff2;
    s3_kb  <= sum2 - d2w[fbik_pkg::SQ_W-1:0];
    s3_d2  <= d2w[fbik_pkg::SQ_W-1:0];
    s3_a   <= u2ml2 + $signed({{(fbik_pkg::A_W - fbik_pkg::SQ_W - 1){1'b0}}, d2w});
  end

  logic [fbik_pkg::K_W-1:0] s4_k;
  fbik_pkg::sq_side_t       s4_sb;

  always_ff @(posedge clk) begin
    s4_k     <= s3_ka * s3_kb;
    s4_sb.bad <= s3_bad;
    s4_sb.bx  <= s3_bx;
    s4_sb.dx  <= s3_dx;
    s4_sb.dy  <= s3_dy;
    s4_sb.a   <= s3_a;
    s4_sb.d2  <= s3_d2;
  end

  // Square root chain.
  logic [fbik_pkg::K_W-1:0]      sq_rad  [fbik_pkg::S_W+1];
  logic [fbik_pkg::SQ_REM_W-1:0] sq_rem  [fbik_pkg::S_W+1];
  logic [fbik_pkg::S_W-1:0]      sq_root [fbik_pkg::S_W+1];
  logic [SW_SQ-1:0]              sq_side [fbik_pkg::S_W+1];

  assign sq_rad[0]  = s4_k;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = s4_sb;

  for (genvar i = 0; i < fbik_pkg::S_W; i++) begin : g_sqrt
    fbik_sqrt_cell #(.SW(SW_SQ)) u_cell (
      .clk      (clk),
      .rad_in   (sq_rad[i]),
      .rem_in   (sq_rem[i]),
      .root_in  (sq_root[i]),
      .side_in  (sq_side[i]),
      .rad_out  (sq_rad[i+1]),
      .rem_out  (sq_rem[i+1]),
      .root_out (sq_root[i+1]),
      .side_out (sq_side[i+1])
    );
  end

  // Numerators of the chosen intersection.
  fbik_pkg::sq_side_t            sq_sb;
  logic [fbik_pkg::S_W-1:0]      sq_s;
  logic                          second;

  assign sq_sb  = sq_side[fbik_pkg::S_W];
  assign sq_s   = sq_root[fbik_pkg::S_W];
  assign second = (sq_s != '0) &&
                  (LEFT ? (!sq_sb.dy[15] && (sq_sb.dy != '0)) : sq_sb.dy[15]);

  logic                            p_bad, p_second;
  logic signed [15:0]              p_bx;
  logic [fbik_pkg::SQ_W-1:0]       p_d2;
  logic signed [fbik_pkg::N_W-1:0] p_ad, p_ay, p_sdx, p_sdy;

  always_ff @(posedge clk) begin
    p_bad    <= sq_sb.bad;
    p_second <= second;
    p_bx     <= sq_sb.bx;
    p_d2     <= sq_sb.d2;
    p_ad     <= sq_sb.a * sq_sb.dx;
    p_ay     <= sq_sb.a * sq_sb.dy;
    p_sdx    <= $signed({1'b0, sq_s}) * sq_sb.dx;
    p_sdy    <= $signed({1'b0, sq_s}) * sq_sb.dy;
  end

  logic                            n_bad;
  logic signed [15:0]              n_bx;
  logic [fbik_pkg::SQ_W-1:0]       n_d2;
  logic signed [fbik_pkg::N_W-1:0] n_nx, n_ny;

  always_ff @(posedge clk) begin
    n_bad <= p_bad;
    n_bx  <= p_bx;
    n_d2  <= p_d2;
    n_nx  <= p_second ? p_ad - p_sdy : p_ad + p_sdy;
    n_ny  <= p_second ? p_ay + p_sdx : p_ay - p_sdx;
  end

  // Rounded division: (|n| + d2) / (2 * d2).
  logic [fbik_pkg::N_W-1:0] absx, absy;
  logic [fbik_pkg::N_W-1:0] m_remx, m_remy, m_dsh;
  fbik_pkg::dv_side_t       m_sb;

  assign absx = n_nx[fbik_pkg::N_W-1] ? $unsigned(-n_nx) : $unsigned(n_nx);
  assign absy = n_ny[fbik_pkg::N_W-1] ? $unsigned(-n_ny) : $unsigned(n_ny);

  always_ff @(posedge clk) begin
    m_remx    <= absx + fbik_pkg::N_W'(n_d2);
    m_remy    <= absy + fbik_pkg::N_W'(n_d2);
    m_dsh     <= fbik_pkg::N_W'({n_d2, 1'b0}) << (fbik_pkg::Q_W - 1);
    m_sb.bad  <= n_bad;
    m_sb.bx   <= n_bx;
    m_sb.nx   <= n_nx;
    m_sb.ny   <= n_ny;
  end

  logic [fbik_pkg::N_W-1:0] dv_remx [fbik_pkg::Q_W+1];
  logic [fbik_pkg::N_W-1:0] dv_remy [fbik_pkg::Q_W+1];
  logic [fbik_pkg::Q_W-1:0] dv_qx   [fbik_pkg::Q_W+1];
  logic [fbik_pkg::Q_W-1:0] dv_qy   [fbik_pkg::Q_W+1];
  logic [fbik_pkg::N_W-1:0] dv_dsh  [fbik_pkg::Q_W+1];
  logic [SW_DV-1:0]         dv_side [fbik_pkg::Q_W+1];

  assign dv_remx[0] = m_remx;
  assign dv_remy[0] = m_remy;
  assign dv_qx[0]   = '0;
  assign dv_qy[0]   = '0;
  assign dv_dsh[0]  = m_dsh;
  assign dv_side[0] = m_sb;

  for (genvar i = 0; i < fbik_pkg::Q_W; i++) begin : g_div
    fbik_div_cell #(.SW(SW_DV)) u_cell (
      .clk      (clk),
      .remx_in  (dv_remx[i]),
      .remy_in  (dv_remy[i]),
      .qx_in    (dv_qx[i]),
      .qy_in    (dv_qy[i]),
      .dsh_in   (dv_dsh[i]),
      .side_in  (dv_side[i]),
      .remx_out (dv_remx[i+1]),
      .remy_out (dv_remy[i+1]),
      .qx_out   (dv_qx[i+1]),
      .qy_out   (dv_qy[i+1]),
      .dsh_out  (dv_dsh[i+1]),
      .side_out (dv_side[i+1])
    );
  end

  fbik_pkg::dv_side_t               dv_sb;
  logic signed [fbik_pkg::Q_W:0]    sqx, sqy;
  logic signed [fbik_pkg::N_W-1:0]  e_x, e_y;
  fbik_pkg::cd_side_t               e_sb;

  assign dv_sb = dv_side[fbik_pkg::Q_W];
  assign sqx   = dv_sb.nx[fbik_pkg::N_W-1] ? -$signed({1'b0, dv_qx[fbik_pkg::Q_W]})
                                            :  $signed({1'b0, dv_qx[fbik_pkg::Q_W]});
  assign sqy   = dv_sb.ny[fbik_pkg::N_W-1] ? -$signed({1'b0, dv_qy[fbik_pkg::Q_W]})
                                            :  $signed({1'b0, dv_qy[fbik_pkg::Q_W]});

  always_ff @(posedge clk) begin
    e_x       <= dv_sb.ny;
    e_y       <= dv_sb.nx;
    e_sb.bad  <= dv_sb.bad;
    e_sb.zero <= (dv_sb.nx == '0) && (dv_sb.ny == '0);
    e_sb.ex   <= fbik_pkg::OUT_W'((fbik_pkg::Q_W + 1)'(dv_sb.bx) + sqx);
    e_sb.ey   <= fbik_pkg::OUT_W'(sqy);
  end

  // Normalization: binary search for the left shift that brings the larger
  // component into the top octave.
  logic signed [fbik_pkg::N_W-1:0] nm_x  [fbik_pkg::NORM_STEPS+1];
  logic signed [fbik_pkg::N_W-1:0] nm_y  [fbik_pkg::NORM_STEPS+1];
  fbik_pkg::cd_side_t              nm_sb [fbik_pkg::NORM_STEPS+1];

  assign nm_x[0]  = e_x;
  assign nm_y[0]  = e_y;
  assign nm_sb[0] = e_sb;

  for (genvar j = 0; j < fbik_pkg::NORM_STEPS; j++) begin : g_norm
    localparam int SH = 1 << (fbik_pkg::NORM_STEPS - 1 - j);
    logic [fbik_pkg::N_W-1:0]        mx, my, mm;
    logic                            fits;
    logic signed [fbik_pkg::N_W-1:0] sx, sy;
    fbik_pkg::cd_side_t              ssb;
    always_comb begin
      mx   = nm_x[j][fbik_pkg::N_W-1] ? $unsigned(-nm_x[j]) : $unsigned(nm_x[j]);
      my   = nm_y[j][fbik_pkg::N_W-1] ? $unsigned(-nm_y[j]) : $unsigned(nm_y[j]);
      mm   = (mx > my) ? mx : my;
      fits = (mm >> (fbik_pkg::N_W - 2 - SH)) == '0;
    end
    always_ff @(posedge clk) begin
      ssb <= nm_sb[j];
      sx  <= fits ? (nm_x[j] <<< SH) : nm_x[j];
      sy  <= fits ? (nm_y[j] <<< SH) : nm_y[j];
    end
    assign nm_sb[j+1] = ssb;
    assign nm_x[j+1]  = sx;
    assign nm_y[j+1]  = sy;
  end

  // Quarter-turn into the right half plane.
  logic signed [fbik_pkg::XY_W-1:0] xe, ye;
  logic signed [fbik_pkg::XY_W-1:0] cd_x  [fbik_pkg::CORDIC_STEPS+1];
  logic signed [fbik_pkg::XY_W-1:0] cd_y  [fbik_pkg::CORDIC_STEPS+1];
  logic signed [fbik_pkg::Z_W-1:0]  cd_z  [fbik_pkg::CORDIC_STEPS+1];
  logic [SW_CD-1:0]                 cd_sd [fbik_pkg::CORDIC_STEPS+1];
  fbik_pkg::cd_side_t               r_sb;
  logic signed [fbik_pkg::XY_W-1:0] r_x, r_y;
  logic signed [fbik_pkg::Z_W-1:0]  r_z;

  assign xe = fbik_pkg::XY_W'(nm_x[fbik_pkg::NORM_STEPS]);
  assign ye = fbik_pkg::XY_W'(nm_y[fbik_pkg::NORM_STEPS]);

  always_ff @(posedge clk) begin
    r_sb <= nm_sb[fbik_pkg::NORM_STEPS];
    if (xe < 0) begin
      if (ye >= 0) begin
        r_x <= ye;
        r_y <= -xe;
        r_z <= fbik_pkg::HALF_PI_Q16;
      end else begin
        r_x <= -ye;
        r_y <= xe;
        r_z <= -fbik_pkg::HALF_PI_Q16;
      end
    end else begin
      r_x <= xe;
      r_y <= ye;
      r_z <= '0;
    end
  end

  assign cd_x[0]  = r_x;
  assign cd_y[0]  = r_y;
  assign cd_z[0]  = r_z;
  assign cd_sd[0] = r_sb;

  for (genvar i = 0; i < fbik_pkg::CORDIC_STEPS; i++) begin : g_cordic
    fbik_cordic_cell #(.SW(SW_CD), .STEP(i)) u_cell (
      .clk      (clk),
      .x_in     (cd_x[i]),
      .y_in     (cd_y[i]),
      .z_in     (cd_z[i]),
      .side_in  (cd_sd[i]),
      .x_out    (cd_x[i+1]),
      .y_out    (cd_y[i+1]),
      .z_out    (cd_z[i+1]),
      .side_out (cd_sd[i+1])
    );
  end

  // Round to Q13 and clamp.
  fbik_pkg::cd_side_t              f_sb;
  logic signed [fbik_pkg::Z_W-1:0] zr;
  logic signed [fbik_pkg::Z_W-1:0] amax;

  assign f_sb = cd_sd[fbik_pkg::CORDIC_STEPS];
  assign zr   = (cd_z[fbik_pkg::CORDIC_STEPS] + fbik_pkg::Z_W'(4)) >>> 3;
  assign amax = fbik_pkg::Z_W'(fbik_pkg::ANGLE_MAX);

  always_ff @(posedge clk) begin
    bad <= f_sb.bad;
    ex  <= f_sb.ex;
    ey  <= f_sb.ey;
    if (f_sb.zero) begin
      angle <= '0;
    end else if (zr > amax) begin
      angle <= fbik_pkg::ANGLE_MAX;
    end else if (zr < -amax) begin
      angle <= -fbik_pkg::ANGLE_MAX;
    end else begin
      angle <= fbik_pkg::ANGLE_W'(zr);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/five_bar_delta_inverse_kinematics.sv =====
// Top level of the five-bar delta inverse kinematics block: configuration
// registers, request capture, both arm pipelines and the result register.
// Depends on fbik_pkg and fbik_side.
//
// A request is taken on every clock edge with start high and busy low; busy is
// high during reset and stays high until the first clock edge with reset low.
// The result appears in the output registers, marked by a one-cycle done pulse,
// and a new request may follow in every cycle. Each arm's pipeline holds the
// square-root cell chain (30 cells), the divider chain (16 cells), the
// normalizer (6 stages) and the CORDIC chain (16 cells); the two arms run
// side by side. The receiver must take each result in its done cycle.
`default_nettype none

module five_bar_delta_inverse_kinematics #(
  parameter int COORD_WIDTH = fbik_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       target_x,
  input  logic signed [COORD_WIDTH-1:0]       target_y,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fbik_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbik_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                done,
  output logic signed [fbik_pkg::ANGLE_W-1:0] left_angle,
  output logic signed [fbik_pkg::ANGLE_W-1:0] right_angle,
  output logic signed [fbik_pkg::OUT_W-1:0]   left_elbow_x,
  output logic signed [fbik_pkg::OUT_W-1:0]   left_elbow_y,
  output logic signed [fbik_pkg::OUT_W-1:0]   right_elbow_x,
  output logic signed [fbik_pkg::OUT_W-1:0]   right_elbow_y,
  output logic                                out_of_range
);

  logic [fbik_pkg::ARM_W-1:0]            half_base;
  logic [fbik_pkg::ARM_W-1:0]            upper_arm_length;
  logic [fbik_pkg::ARM_W-1:0]            lower_arm_length;
  logic signed [fbik_pkg::ANGLE_W-1:0]   safe_angle;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_base        <= fbik_pkg::HALF_BASE_RST;
      upper_arm_length <= fbik_pkg::UPPER_ARM_RST;
      lower_arm_length <= fbik_pkg::LOWER_ARM_RST;
      safe_angle       <= fbik_pkg::SAFE_ANGLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (fbik_pkg::cfg_reg_t'(cfg_index))
        fbik_pkg::REG_HALF_BASE:  half_base        <= cfg_data[fbik_pkg::ARM_W-1:0];
        fbik_pkg::REG_UPPER_ARM:  upper_arm_length <= cfg_data[fbik_pkg::ARM_W-1:0];
        fbik_pkg::REG_LOWER_ARM:  lower_arm_length <= cfg_data[fbik_pkg::ARM_W-1:0];
        fbik_pkg::REG_SAFE_ANGLE: safe_angle       <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Arm geometry derived from the registers.
  logic [fbik_pkg::SUM_W-1:0]      arm_sum;
  logic [fbik_pkg::ARM_W-1:0]      arm_diff;
  logic [2*fbik_pkg::ARM_W-1:0]    u_sq, l_sq;
  logic [fbik_pkg::SQ_W-1:0]       sum2, diff2;
  logic signed [fbik_pkg::A_W-1:0] u2ml2;

  assign arm_sum  = {1'b0, upper_arm_length} + {1'b0, lower_arm_length};
  assign arm_diff = (upper_arm_length > lower_arm_length) ?
                    upper_arm_length - lower_arm_length :
                    lower_arm_length - upper_arm_length;
  assign u_sq     = upper_arm_length * upper_arm_length;
  assign l_sq     = lower_arm_length * lower_arm_length;

  always_ff @(posedge clk) begin
    sum2  <= arm_sum * arm_sum;
    diff2 <= fbik_pkg::SQ_W'(arm_diff * arm_diff);
    u2ml2 <= $signed({{(fbik_pkg::A_W - 2*fbik_pkg::ARM_W){1'b0}}, u_sq}) -
             $signed({{(fbik_pkg::A_W - 2*fbik_pkg::ARM_W){1'b0}}, l_sq});
  end

  logic                          accept;
  logic signed [COORD_WIDTH-1:0] tx, ty;
  logic [fbik_pkg::SIDE_LAT:0]   vld;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[fbik_pkg::SIDE_LAT-1:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    tx <= target_x;
    ty <= target_y;
  end

  logic                                l_bad, r_bad;
  logic signed [fbik_pkg::OUT_W-1:0]   l_ex, l_ey, r_ex, r_ey;
  logic signed [fbik_pkg::ANGLE_W-1:0] l_ang, r_ang;

  fbik_side #(.CW(COORD_WIDTH), .LEFT(1'b1)) u_left (
    .clk     (clk),
    .tx      (tx),
    .ty      (ty),
    .hb      (half_base),
    .arm_sum (arm_sum),
    .sum2    (sum2),
    .diff2   (diff2),
    .u2ml2   (u2ml2),
    .bad     (l_bad),
    .ex      (l_ex),
    .ey      (l_ey),
    .angle   (l_ang)
  );

  fbik_side #(.CW(COORD_WIDTH), .LEFT(1'b0)) u_right (
    .clk     (clk),
    .tx      (tx),
    .ty      (ty),
    .hb      (half_base),
    .arm_sum (arm_sum),
    .sum2    (sum2),
    .diff2   (diff2),
    .u2ml2   (u2ml2),
    .bad     (r_bad),
    .ex      (r_ex),
    .ey      (r_ey),
    .angle   (r_ang)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[fbik_pkg::SIDE_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (l_bad || r_bad) begin
      left_angle    <= safe_angle;
      right_angle   <= safe_angle;
      left_elbow_x  <= '0;
      left_elbow_y  <= '0;
      right_elbow_x <= '0;
      right_elbow_y <= '0;
      out_of_range  <= 1'b1;
    end else begin
      left_angle    <= -l_ang;
      right_angle   <= r_ang;
      left_elbow_x  <= l_ex;
      left_elbow_y  <= l_ey;
      right_elbow_x <= r_ex;
      right_elbow_y <= r_ey;
      out_of_range  <= 1'b0;
    end
  end

endmodule

`default_nettype wire
